FILE: hw/rtl/bdcs_pkg.sv
package bdcs_pkg;

    localparam int POS_W   = 16;
    localparam int AGE_W   = 20;
    localparam int DIV_NW  = 49;
    localparam int DIV_DW  = 26;
    localparam int DIV_CW  = 6;

    localparam logic [10:0] WIDTH_RST  = 11'd800;
    localparam logic [10:0] HEIGHT_RST = 11'd600;
    localparam logic [7:0]  RADIUS_RST = 8'd50;
    localparam logic [19:0] AGE_RST    = 20'd655360;
    localparam logic [19:0] AGE_MAX    = 20'hFFFFF;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_RADIUS = 3'd2;
    localparam logic [2:0] CFG_AGE    = 3'd3;

    localparam logic [1:0] KIND_POS   = 2'd0;
    localparam logic [1:0] KIND_SPAWN = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] vx;
        logic signed [POS_W-1:0] vy;
        logic [AGE_W-1:0]        age;
    } disc_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_RD, OP_MULX, OP_ADDX, OP_MVWR, OP_LDI, OP_SQX, OP_SQY,
        OP_D2, OP_DOTX, OP_DOTY, OP_DOT, OP_NUMX, OP_NUMY, OP_DIV, OP_QX,
        OP_QY, OP_UPD, OP_WRI, OP_CPY, OP_LDCLK, OP_EMPOS, OP_EMEMPTY,
        OP_EMSPAWN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   take;
        logic   last;
        logic   acc;
    } dp_cmd_t;

    typedef struct packed {
        logic le;
        logic nz;
        logic expired;
        logic border_ok;
        logic out_free;
        logic div_done;
    } dp_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MV_RD, ST_MV_MULX, ST_MV_ADDX, ST_MV_WR,
        ST_PR_I, ST_PR_LDI, ST_PR_J, ST_PR_SQX, ST_PR_SQY, ST_PR_D2, ST_PR_CHK,
        ST_PR_DOTX, ST_PR_DOTY, ST_PR_DOT, ST_PR_NUMX, ST_PR_DIVX, ST_PR_WX,
        ST_PR_NUMY, ST_PR_DIVY, ST_PR_WY, ST_PR_UPD, ST_PR_WRI,
        ST_CP_RD, ST_CP_CHK, ST_EM_START, ST_EM_EMPTY, ST_EM_RD, ST_EM_OUT,
        ST_SP_LD, ST_SP_RD, ST_SP_ANS
    } state_t;

    typedef enum logic [1:0] {
        SS_SQX, SS_SQY, SS_D2, SS_CHK
    } sub_t;

    function automatic logic signed [15:0] sat16(logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767) r = 16'sh7FFF;
        else if (v < -22'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] neg16(logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000) r = 16'sh7FFF;
        else r = -v;
        return r;
    endfunction

    function automatic logic signed [15:0] bounce(logic signed [15:0] p,
                                                  logic signed [15:0] v,
                                                  logic [14:0] lim,
                                                  logic [11:0] r16);
        logic signed [17:0] pe;
        logic signed [17:0] re;
        logic signed [15:0] o;
        pe = {{2{p[15]}}, p};
        re = $signed({6'b0, r16});
        o  = v;
        if ((pe + re) >= $signed({3'b0, lim}) && o > 16'sd0) o = neg16(o);
        if (pe < re && o < 16'sd0) o = neg16(o);
        return o;
    endfunction

endpackage

FILE: hw/rtl/bdcs_div.sv
module bdcs_div
    import bdcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_NW-1:0] quo,
    output logic              done
);

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   trial;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_NW-1]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DIV_DW]) begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/bdcs_ctrl.sv
module bdcs_ctrl
    import bdcs_pkg::*;
#(
    parameter int MAX_DISCS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_op,
    output logic                           s_ready,
    input  dp_sts_t                        sts,
    output dp_cmd_t                        cmd,
    output logic [$clog2(MAX_DISCS)-1:0]   addr
);

    localparam int IW = $clog2(MAX_DISCS);
    localparam int CW = $clog2(MAX_DISCS + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] w_reg, w_next;
    logic          ok_reg, ok_next;
    logic [CW:0]   i_inc;
    logic          i_end, j_end, i_last, full;
    logic [CW-1:0] a_sel;

    assign i_inc  = {1'b0, i_reg} + 1'b1;
    assign i_end  = (i_reg == n_reg);
    assign j_end  = (j_reg == n_reg);
    assign i_last = (i_inc == {1'b0, n_reg});
    assign full   = (n_reg == CW'(MAX_DISCS));

    always_comb begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        n_next = n_reg;
        w_next = w_reg;
        ok_next = ok_reg;
        case (state_reg)
            ST_IDLE: begin
                i_next = '0;
                if (s_valid) state_next = s_op ? ST_SP_LD : ST_MV_RD;
            end
            ST_MV_RD: begin
                if (i_end) begin
                    state_next = ST_PR_I;
                    i_next = '0;
                end else state_next = ST_MV_MULX;
            end
            ST_MV_MULX: state_next = ST_MV_ADDX;
            ST_MV_ADDX: state_next = ST_MV_WR;
            ST_MV_WR: begin
                i_next = i_inc[CW-1:0];
                state_next = ST_MV_RD;
            end
            ST_PR_I: begin
                if (i_inc >= {1'b0, n_reg}) begin
                    state_next = ST_CP_RD;
                    i_next = '0;
                    w_next = '0;
                end else state_next = ST_PR_LDI;
            end
            ST_PR_LDI: begin
                j_next = i_inc[CW-1:0];
                state_next = ST_PR_J;
            end
            ST_PR_J: state_next = j_end ? ST_PR_WRI : ST_PR_SQX;
            ST_PR_SQX: state_next = ST_PR_SQY;
            ST_PR_SQY: state_next = ST_PR_D2;
            ST_PR_D2: state_next = ST_PR_CHK;
            ST_PR_CHK: begin
                if (sts.le && sts.nz) state_next = ST_PR_DOTX;
                else begin
                    j_next = j_reg + 1'b1;
                    state_next = ST_PR_J;
                end
            end
            ST_PR_DOTX: state_next = ST_PR_DOTY;
            ST_PR_DOTY: state_next = ST_PR_DOT;
            ST_PR_DOT: state_next = ST_PR_NUMX;
            ST_PR_NUMX: state_next = ST_PR_DIVX;
            ST_PR_DIVX: state_next = ST_PR_WX;
            ST_PR_WX: if (sts.div_done) state_next = ST_PR_NUMY;
            ST_PR_NUMY: state_next = ST_PR_DIVY;
            ST_PR_DIVY: state_next = ST_PR_WY;
            ST_PR_WY: if (sts.div_done) state_next = ST_PR_UPD;
            ST_PR_UPD: begin
                j_next = j_reg + 1'b1;
                state_next = ST_PR_J;
            end
            ST_PR_WRI: begin
                i_next = i_inc[CW-1:0];
                state_next = ST_PR_I;
            end
            ST_CP_RD: begin
                if (i_end) begin
                    n_next = w_reg;
                    state_next = ST_EM_START;
                end else state_next = ST_CP_CHK;
            end
            ST_CP_CHK: begin
                if (!sts.expired) w_next = w_reg + 1'b1;
                i_next = i_inc[CW-1:0];
                state_next = ST_CP_RD;
            end
            ST_EM_START: begin
                i_next = '0;
                state_next = (n_reg == '0) ? ST_EM_EMPTY : ST_EM_RD;
            end
            ST_EM_EMPTY: if (sts.out_free) state_next = ST_IDLE;
            ST_EM_RD: state_next = ST_EM_OUT;
            ST_EM_OUT: begin
                if (sts.out_free) begin
                    i_next = i_inc[CW-1:0];
                    state_next = i_last ? ST_IDLE : ST_EM_RD;
                end
            end
            ST_SP_LD: begin
                ok_next = sts.border_ok && !full;
                i_next = '0;
                state_next = ST_SP_RD;
            end
            ST_SP_RD: state_next = i_end ? ST_SP_ANS : ST_PR_SQX;
            ST_SP_ANS: begin
                if (sts.out_free) begin
                    if (ok_reg) n_next = n_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the proximity test of a spawn shares the pair squaring states
    sub_t sub_unused;
    logic sp_mode_reg, sp_mode_next;

    always_comb begin
        sub_unused = SS_SQX;
        sp_mode_next = sp_mode_reg;
        if (state_reg == ST_SP_LD) sp_mode_next = 1'b1;
        else if (state_reg == ST_MV_RD) sp_mode_next = 1'b0;
    end

    always_comb begin
        cmd = '{op: OP_NONE, take: 1'b0, last: 1'b0, acc: 1'b0};
        a_sel = i_reg;
        s_ready = (state_reg == ST_IDLE);
        cmd.take = s_ready && s_valid;
        case (state_reg)
            ST_MV_RD, ST_PR_I, ST_CP_RD, ST_SP_RD: begin
                if (!i_end && !(state_reg == ST_PR_I && i_inc >= {1'b0, n_reg}))
                    cmd.op = OP_RD;
            end
            ST_EM_RD: cmd.op = OP_RD;
            ST_MV_MULX: cmd.op = OP_MULX;
            ST_MV_ADDX: cmd.op = OP_ADDX;
            ST_MV_WR: cmd.op = OP_MVWR;
            ST_PR_LDI: cmd.op = OP_LDI;
            ST_PR_J: begin
                a_sel = j_reg;
                if (!j_end) cmd.op = OP_RD;
            end
            ST_PR_SQX: cmd.op = OP_SQX;
            ST_PR_SQY: cmd.op = OP_SQY;
            ST_PR_D2: cmd.op = OP_D2;
            ST_PR_DOTX: cmd.op = OP_DOTX;
            ST_PR_DOTY: cmd.op = OP_DOTY;
            ST_PR_DOT: cmd.op = OP_DOT;
            ST_PR_NUMX: cmd.op = OP_NUMX;
            ST_PR_NUMY: cmd.op = OP_NUMY;
            ST_PR_DIVX, ST_PR_DIVY: cmd.op = OP_DIV;
            ST_PR_WX: if (sts.div_done) cmd.op = OP_QX;
            ST_PR_WY: if (sts.div_done) cmd.op = OP_QY;
            ST_PR_UPD: begin
                a_sel = j_reg;
                cmd.op = OP_UPD;
            end
            ST_PR_WRI: cmd.op = OP_WRI;
            ST_CP_CHK: begin
                a_sel = w_reg;
                if (!sts.expired) cmd.op = OP_CPY;
            end
            ST_EM_EMPTY: if (sts.out_free) cmd.op = OP_EMEMPTY;
            ST_EM_OUT: begin
                cmd.last = i_last;
                if (sts.out_free) cmd.op = OP_EMPOS;
            end
            ST_SP_LD: cmd.op = OP_LDCLK;
            ST_SP_ANS: begin
                a_sel = n_reg;
                cmd.acc = ok_reg;
                cmd.last = 1'b1;
                if (sts.out_free) cmd.op = OP_EMSPAWN;
            end
            default: cmd.op = OP_NONE;
        endcase
        addr = a_sel[IW-1:0];
    end

    logic chk_sp;
    assign chk_sp = sp_mode_reg && (sub_unused == SS_SQX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            n_reg <= '0;
            w_reg <= '0;
            ok_reg <= 1'b0;
            sp_mode_reg <= 1'b0;
        end else begin
            if (state_reg == ST_PR_CHK && chk_sp) begin
                // spawn proximity check: a hit rejects, then on to the next disc
                if (sts.le) ok_reg <= 1'b0;
                i_reg <= i_inc[CW-1:0];
                state_reg <= ST_SP_RD;
            end else begin
                state_reg <= state_next;
                i_reg <= i_next;
                ok_reg <= ok_next;
            end
            j_reg <= j_next;
            n_reg <= n_next;
            w_reg <= w_next;
            sp_mode_reg <= sp_mode_next;
        end
    end

endmodule

FILE: hw/rtl/bdcs_dp.sv
module bdcs_dp
    import bdcs_pkg::*;
#(
    parameter int MAX_DISCS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  dp_cmd_t                      cmd,
    input  logic [$clog2(MAX_DISCS)-1:0] addr,
    output dp_sts_t                      sts,
    input  logic                         cfg_valid,
    input  logic [2:0]                   cfg_index,
    input  logic [19:0]                  cfg_data,
    input  logic [15:0]                  s_delta_time,
    input  logic [10:0]                  s_click_x,
    input  logic [10:0]                  s_click_y,
    input  logic signed [15:0]           s_new_speed_x,
    input  logic signed [15:0]           s_new_speed_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [3:0]                   m_slot,
    output logic signed [15:0]           m_pos_x,
    output logic signed [15:0]           m_pos_y,
    output logic                         m_accepted,
    output logic                         m_last
);

    localparam int IW = $clog2(MAX_DISCS);

    disc_t mem [MAX_DISCS];

    logic [10:0] width_reg, height_reg;
    logic [7:0]  radius_reg;
    logic [19:0] lim_reg;
    logic [15:0] dt_reg;
    logic [10:0] cx_reg, cy_reg;
    logic signed [15:0] nvx_reg, nvy_reg;

    disc_t rd_reg, ri_reg;
    logic signed [49:0] prod_reg, acc_reg;
    logic signed [15:0] nx_reg;
    logic [33:0]        d2_reg;
    logic               le_reg, nz_reg;
    logic signed [31:0] dot_reg;
    logic signed [20:0] qx_reg, qy_reg;

    logic               mv_reg;
    logic [1:0]         kind_reg;
    logic [3:0]         slot_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic               oacc_reg, olast_reg;

    logic signed [16:0] dx, dy, dvx, dvy;
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [49:0] sum_p, shp;
    logic signed [15:0] ny, bvx, bvy;
    logic [20:0]        age_sum;
    logic [19:0]        age_new;
    logic [15:0]        rr;
    logic [25:0]        reach2;
    logic signed [11:0] cxs, cys, rs, wr, hr;
    logic [IW+3:0]      slot_ext;
    logic [DIV_NW-1:0]  num_mag, quo;
    logic [49:0]        prod_abs;
    logic signed [20:0] q_val;
    logic               div_done;
    logic               we;
    disc_t              wdata, rd_upd, ri_upd;

    assign dx  = {rd_reg.px[15], rd_reg.px} - {ri_reg.px[15], ri_reg.px};
    assign dy  = {rd_reg.py[15], rd_reg.py} - {ri_reg.py[15], ri_reg.py};
    assign dvx = {rd_reg.vx[15], rd_reg.vx} - {ri_reg.vx[15], ri_reg.vx};
    assign dvy = {rd_reg.vy[15], rd_reg.vy} - {ri_reg.vy[15], ri_reg.vy};

    always_comb begin
        mul_a = dx;
        mul_b = {{16{dx[16]}}, dx};
        case (cmd.op)
            OP_MULX: begin
                mul_a = {rd_reg.vx[15], rd_reg.vx};
                mul_b = $signed({17'b0, dt_reg});
            end
            OP_ADDX: begin
                mul_a = {rd_reg.vy[15], rd_reg.vy};
                mul_b = $signed({17'b0, dt_reg});
            end
            OP_SQY: begin
                mul_a = dy;
                mul_b = {{16{dy[16]}}, dy};
            end
            OP_DOTX: mul_b = {{16{dvx[16]}}, dvx};
            OP_DOTY: begin
                mul_a = dy;
                mul_b = {{16{dvy[16]}}, dvy};
            end
            OP_NUMX: mul_b = {dot_reg[31], dot_reg};
            OP_NUMY: begin
                mul_a = dy;
                mul_b = {dot_reg[31], dot_reg};
            end
            default: mul_b = {{16{dx[16]}}, dx};
        endcase
        mul_p = mul_a * mul_b;
    end

    assign sum_p   = acc_reg + prod_reg;
    assign shp     = prod_reg >>> 16;
    assign ny      = sat16({{6{rd_reg.py[15]}}, rd_reg.py} + shp[21:0]);
    assign bvx     = bounce(nx_reg, rd_reg.vx, {width_reg, 4'b0}, {radius_reg, 4'b0});
    assign bvy     = bounce(ny, rd_reg.vy, {height_reg, 4'b0}, {radius_reg, 4'b0});
    assign age_sum = {1'b0, rd_reg.age} + {5'b0, dt_reg};
    assign age_new = age_sum[20] ? AGE_MAX : age_sum[19:0];

    assign rr     = radius_reg * radius_reg;
    assign reach2 = {rr, 10'b0};

    assign cxs = $signed({1'b0, cx_reg});
    assign cys = $signed({1'b0, cy_reg});
    assign rs  = $signed({4'b0, radius_reg});
    assign wr  = $signed({1'b0, width_reg}) - rs;
    assign hr  = $signed({1'b0, height_reg}) - rs;

    assign prod_abs = prod_reg[49] ? 50'(-prod_reg) : 50'(prod_reg);
    assign num_mag  = prod_abs[DIV_NW-1:0];
    assign q_val    = prod_reg[49] ? -$signed({1'b0, quo[19:0]}) : $signed({1'b0, quo[19:0]});

    bdcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_DIV),
        .num     (num_mag),
        .den     (d2_reg[DIV_DW-1:0]),
        .quo     (quo),
        .done    (div_done)
    );

    always_comb begin
        rd_upd = rd_reg;
        ri_upd = ri_reg;
        rd_upd.vx = sat16({{6{rd_reg.vx[15]}}, rd_reg.vx} - {qx_reg[20], qx_reg});
        rd_upd.vy = sat16({{6{rd_reg.vy[15]}}, rd_reg.vy} - {qy_reg[20], qy_reg});
        ri_upd.vx = sat16({{6{ri_reg.vx[15]}}, ri_reg.vx} + {qx_reg[20], qx_reg});
        ri_upd.vy = sat16({{6{ri_reg.vy[15]}}, ri_reg.vy} + {qy_reg[20], qy_reg});
        we = 1'b0;
        wdata = rd_reg;
        case (cmd.op)
            OP_MVWR: begin
                we = 1'b1;
                wdata = '{px: nx_reg, py: ny, vx: bvx, vy: bvy, age: age_new};
            end
            OP_UPD: begin
                we = 1'b1;
                wdata = rd_upd;
            end
            OP_WRI: begin
                we = 1'b1;
                wdata = ri_reg;
            end
            OP_CPY: we = 1'b1;
            OP_EMSPAWN: begin
                we = cmd.acc;
                wdata = ri_reg;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        if (cmd.op == OP_RD) rd_reg <= mem[addr];
    end

    assign slot_ext = {4'b0, addr};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            radius_reg <= RADIUS_RST;
            lim_reg    <= AGE_RST;
            mv_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                    CFG_HEIGHT: height_reg <= cfg_data[10:0];
                    CFG_RADIUS: radius_reg <= cfg_data[7:0];
                    CFG_AGE:    lim_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_EMPOS || cmd.op == OP_EMEMPTY || cmd.op == OP_EMSPAWN)
                mv_reg <= 1'b1;
            else if (m_ready)
                mv_reg <= 1'b0;
        end
        if (cmd.take) begin
            dt_reg  <= s_delta_time;
            cx_reg  <= s_click_x;
            cy_reg  <= s_click_y;
            nvx_reg <= s_new_speed_x;
            nvy_reg <= s_new_speed_y;
        end
        case (cmd.op)
            OP_MULX, OP_SQX, OP_DOTX, OP_NUMX, OP_NUMY: prod_reg <= mul_p;
            OP_ADDX: begin
                nx_reg   <= sat16({{6{rd_reg.px[15]}}, rd_reg.px} + shp[21:0]);
                prod_reg <= mul_p;
            end
            OP_SQY, OP_DOTY: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_D2: begin
                d2_reg <= sum_p[33:0];
                le_reg <= (sum_p[33:0] <= {8'b0, reach2});
                nz_reg <= (sum_p[33:0] != '0);
            end
            OP_DOT: dot_reg <= sum_p[31:0];
            OP_QX: qx_reg <= q_val;
            OP_QY: qy_reg <= q_val;
            OP_LDI: ri_reg <= rd_reg;
            OP_UPD: ri_reg <= ri_upd;
            OP_LDCLK: ri_reg <= '{px: $signed({1'b0, cx_reg, 4'b0}),
                                  py: $signed({1'b0, cy_reg, 4'b0}),
                                  vx: nvx_reg, vy: nvy_reg, age: '0};
            default: ;
        endcase
        case (cmd.op)
            OP_EMPOS: begin
                kind_reg <= KIND_POS;
                slot_reg <= slot_ext[3:0];
                ox_reg <= rd_reg.px;
                oy_reg <= rd_reg.py;
                oacc_reg <= 1'b0;
                olast_reg <= cmd.last;
            end
            OP_EMEMPTY: begin
                kind_reg <= KIND_EMPTY;
                slot_reg <= '0;
                ox_reg <= '0;
                oy_reg <= '0;
                oacc_reg <= 1'b0;
                olast_reg <= 1'b1;
            end
            OP_EMSPAWN: begin
                kind_reg <= KIND_SPAWN;
                slot_reg <= cmd.acc ? slot_ext[3:0] : 4'd0;
                ox_reg <= cmd.acc ? ri_reg.px : 16'sd0;
                oy_reg <= cmd.acc ? ri_reg.py : 16'sd0;
                oacc_reg <= cmd.acc;
                olast_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign sts.le        = le_reg;
    assign sts.nz        = nz_reg;
    assign sts.expired   = rd_reg.age > lim_reg;
    assign sts.border_ok = !(cxs <= rs || cys <= rs || cxs >= wr || cys >= hr);
    assign sts.out_free  = !mv_reg || m_ready;
    assign sts.div_done  = div_done;

    assign m_valid    = mv_reg;
    assign m_kind     = kind_reg;
    assign m_slot     = slot_reg;
    assign m_pos_x    = ox_reg;
    assign m_pos_y    = oy_reg;
    assign m_accepted = oacc_reg;
    assign m_last     = olast_reg;

endmodule

FILE: hw/rtl/bouncing_disc_collision_step.sv
// channel  | handshake            | payload
// s_       | s_valid / s_ready    | op, delta_time, click_x/y, new_speed_x/y
// m_       | m_valid / m_ready    | kind, slot, pos_x/y, accepted, last
// cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data
// One request at a time. A tick moves the discs, tests every pair with two
// 49-step divisions per close pair, then compacts and outputs the table.
// Synchronous active-low reset empties the table; stores hold no reset.
// A stalled m_ready holds the result register and the sequencer waits.
module bouncing_disc_collision_step
    import bdcs_pkg::*;
#(
    parameter int MAX_DISCS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [15:0]        s_delta_time,
    input  logic [10:0]        s_click_x,
    input  logic [10:0]        s_click_y,
    input  logic signed [15:0] s_new_speed_x,
    input  logic signed [15:0] s_new_speed_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [3:0]         m_slot,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic               m_accepted,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [$clog2(MAX_DISCS)-1:0] addr;

    assign cfg_ready = 1'b1;

    bdcs_ctrl #(.MAX_DISCS(MAX_DISCS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd),
        .addr    (addr)
    );

    bdcs_dp #(.MAX_DISCS(MAX_DISCS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .addr          (addr),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_delta_time  (s_delta_time),
        .s_click_x     (s_click_x),
        .s_click_y     (s_click_y),
        .s_new_speed_x (s_new_speed_x),
        .s_new_speed_y (s_new_speed_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_slot        (m_slot),
        .m_pos_x       (m_pos_x),
        .m_pos_y       (m_pos_y),
        .m_accepted    (m_accepted),
        .m_last        (m_last)
    );

endmodule

FILE: hw/rtl/bdcs_chk.sv
module bdcs_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_kind,
    input logic [3:0]         m_slot,
    input logic signed [15:0] m_pos_x,
    input logic signed [15:0] m_pos_y,
    input logic               m_accepted,
    input logic               m_last
);

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_kind))
        else $error("stalled result dropped or changed");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != 2'd0 |-> m_last)
        else $error("spawn or empty answer not last");

    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == 2'd2 || (m_kind == 2'd1 && !m_accepted))
        |-> m_slot == 4'd0 && m_pos_x == 16'sd0 && m_pos_y == 16'sd0)
        else $error("empty or rejected answer carries data");

endmodule

bind bouncing_disc_collision_step bdcs_chk u_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_slot     (m_slot),
    .m_pos_x    (m_pos_x),
    .m_pos_y    (m_pos_y),
    .m_accepted (m_accepted),
    .m_last     (m_last)
);

FILE: sim/disc_table_checker.sv
module disc_table_checker
    import bdcs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_op,
    input  logic [15:0]        s_delta_time,
    input  logic [10:0]        s_click_x,
    input  logic [10:0]        s_click_y,
    input  logic signed [15:0] s_new_speed_x,
    input  logic signed [15:0] s_new_speed_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_kind,
    input  logic [3:0]         m_slot,
    input  logic signed [15:0] m_pos_x,
    input  logic signed [15:0] m_pos_y,
    input  logic               m_accepted,
    input  logic               m_last,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam int NDISC = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         slot;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               acc;
        logic               last;
    } answer_t;

    answer_t answer_q[$];

    longint unsigned fw, fh, rad, alim;
    longint tx[NDISC], ty[NDISC], tvx[NDISC], tvy[NDISC];
    longint unsigned tage[NDISC];
    int live;

    assign pending = answer_q.size();

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint reflect(longint p, longint v, longint lim);
        longint r;
        r = rad * 16;
        if (p + r >= lim && v > 0) v = clip16(-v);
        if (p < r && v < 0) v = clip16(-v);
        return v;
    endfunction

    task automatic push_answer(logic [1:0] k, int s, longint px, longint py,
                               logic acc, logic lst);
        answer_t a;
        a.kind = k;
        a.slot = s[3:0];
        a.px = px[15:0];
        a.py = py[15:0];
        a.acc = acc;
        a.last = lst;
        answer_q.push_back(a);
    endtask

    task automatic advance_frame(longint dt);
        longint reach, dx, dy, d2, dvx, dvy, dot, qx, qy, m;
        longint unsigned a;
        int w;
        reach = rad * 32;
        for (int i = 0; i < live; i++) begin
            m = tvx[i] * dt;
            tx[i] = clip16(tx[i] + (m >>> 16));
            m = tvy[i] * dt;
            ty[i] = clip16(ty[i] + (m >>> 16));
            a = tage[i] + dt;
            tage[i] = (a > 64'hFFFFF) ? 64'hFFFFF : a;
            tvx[i] = reflect(tx[i], tvx[i], fw * 16);
            tvy[i] = reflect(ty[i], tvy[i], fh * 16);
        end
        for (int i = 0; i < live; i++) begin
            for (int j = i + 1; j < live; j++) begin
                dx = tx[j] - tx[i];
                dy = ty[j] - ty[i];
                d2 = dx * dx + dy * dy;
                if (d2 != 0 && d2 <= reach * reach) begin
                    dvx = tvx[j] - tvx[i];
                    dvy = tvy[j] - tvy[i];
                    dot = dx * dvx + dy * dvy;
                    qx = dx * dot / d2;
                    qy = dy * dot / d2;
                    tvx[i] = clip16(tvx[i] + qx);
                    tvy[i] = clip16(tvy[i] + qy);
                    tvx[j] = clip16(tvx[j] - qx);
                    tvy[j] = clip16(tvy[j] - qy);
                end
            end
        end
        w = 0;
        for (int i = 0; i < live; i++) begin
            if (tage[i] <= alim) begin
                tx[w] = tx[i];
                ty[w] = ty[i];
                tvx[w] = tvx[i];
                tvy[w] = tvy[i];
                tage[w] = tage[i];
                w++;
            end
        end
        live = w;
        if (live == 0) begin
            push_answer(KIND_EMPTY, 0, 0, 0, 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < live; i++)
                push_answer(KIND_POS, i, tx[i], ty[i], 1'b0, i == live - 1);
        end
    endtask

    task automatic try_spawn(longint cx, longint cy, longint vx, longint vy);
        longint r, reach, dx, dy;
        bit ok;
        r = rad;
        reach = r * 32;
        ok = !(cx <= r || cy <= r || cx >= longint'(fw) - r || cy >= longint'(fh) - r);
        if (live >= NDISC) ok = 0;
        for (int i = 0; i < live; i++) begin
            dx = cx * 16 - tx[i];
            dy = cy * 16 - ty[i];
            if (dx * dx + dy * dy <= reach * reach) ok = 0;
        end
        if (!ok) begin
            push_answer(KIND_SPAWN, 0, 0, 0, 1'b0, 1'b1);
        end else begin
            tx[live] = cx * 16;
            ty[live] = cy * 16;
            tvx[live] = vx;
            tvy[live] = vy;
            tage[live] = 0;
            push_answer(KIND_SPAWN, live, cx * 16, cy * 16, 1'b1, 1'b1);
            live++;
        end
    endtask

    always @(posedge aclk) begin
        answer_t e;
        if (!aresetn) begin
            fw <= WIDTH_RST;
            fh <= HEIGHT_RST;
            rad <= RADIUS_RST;
            alim <= AGE_RST;
            live = 0;
            fail_count = 0;
            answer_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WIDTH:  fw <= cfg_data[10:0];
                    CFG_HEIGHT: fh <= cfg_data[10:0];
                    CFG_RADIUS: rad <= cfg_data[7:0];
                    CFG_AGE:    alim <= cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_op == 1'b0)
                    advance_frame(s_delta_time);
                else
                    try_spawn(s_click_x, s_click_y, s_new_speed_x, s_new_speed_y);
            end
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0d slot=%0d x=%0d y=%0d",
                             $time, m_kind, m_slot, m_pos_x, m_pos_y);
                    fail_count++;
                end else begin
                    e = answer_q.pop_front();
                    if (e.kind !== m_kind || e.slot !== m_slot || e.px !== m_pos_x ||
                        e.py !== m_pos_y || e.acc !== m_accepted || e.last !== m_last) begin
                        $display("%0t: mismatch exp k=%0d s=%0d x=%0d y=%0d a=%0d l=%0d",
                                 $time, e.kind, e.slot, e.px, e.py, e.acc, e.last);
                        $display("%0t:          got k=%0d s=%0d x=%0d y=%0d a=%0d l=%0d",
                                 $time, m_kind, m_slot, m_pos_x, m_pos_y, m_accepted,
                                 m_last);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/testbench.sv
module testbench;
    import bdcs_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [15:0]        s_delta_time = '0;
    logic [10:0]        s_click_x = '0;
    logic [10:0]        s_click_y = '0;
    logic signed [15:0] s_new_speed_x = '0;
    logic signed [15:0] s_new_speed_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_kind;
    logic [3:0]         m_slot;
    logic signed [15:0] m_pos_x;
    logic signed [15:0] m_pos_y;
    logic               m_accepted;
    logic               m_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 stall_mode = 0;

    localparam int CYCLE_LIMIT = 3000000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern, switched per phase
    always @(posedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    bouncing_disc_collision_step i_dut (.*);

    disc_table_checker i_checker (.*);

    task automatic send_request(logic op, logic [15:0] dt, logic [10:0] cx,
                                logic [10:0] cy, logic [15:0] vx, logic [15:0] vy);
        s_valid <= 1'b1;
        s_op <= op;
        s_delta_time <= dt;
        s_click_x <= cx;
        s_click_y <= cy;
        s_new_speed_x <= vx;
        s_new_speed_y <= vy;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic random_burst(int count, int w, int h, int r);
        int burst;
        int done;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if ($urandom_range(0, 2) == 0)
                    send_request(1'b0, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 8000),
                                 $urandom, $urandom, $urandom, $urandom);
                else if ($urandom_range(0, 7) == 0)
                    send_request(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    send_request(1'b1, $urandom, $urandom_range(0, w), $urandom_range(0, h),
                                 $urandom_range(0, 4000) - 2000,
                                 $urandom_range(0, 4000) - 2000);
                done++;
            end
            idle_gap();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, empty tick, borders, crowding and full table
        send_request(1'b0, 16'd0, 0, 0, 0, 0);
        send_request(1'b1, 16'hFFFF, 11'd50, 11'd300, 16'sd100, 16'sd0);
        send_request(1'b1, 16'd0, 11'd750, 11'd300, 16'sd100, 16'sd0);
        send_request(1'b1, 16'd0, 11'd2047, 11'd2047, 16'sh7FFF, 16'sh8000);
        send_request(1'b1, 16'd0, 11'd200, 11'd200, 16'sh7FFF, 16'sh8000);
        send_request(1'b1, 16'd0, 11'd299, 11'd200, 16'sd0, 16'sd0);
        send_request(1'b1, 16'd0, 11'd300, 11'd200, 16'sh8000, 16'sh7FFF);
        send_request(1'b0, 16'hFFFF, 0, 0, 0, 0);
        send_request(1'b0, 16'd1, 0, 0, 0, 0);
        drain();

        write_reg(CFG_WIDTH, 20'd2047);
        write_reg(CFG_HEIGHT, 20'd2047);
        write_reg(CFG_RADIUS, 20'd1);
        write_reg(CFG_AGE, 20'hFFFFF);
        stall_mode = 1;
        for (int k = 0; k < 17; k++)
            send_request(1'b1, 0, 11'd10 + 11'(k * 100), 11'd1000, 16'sd16, -16'sd16);
        send_request(1'b0, 16'd4096, 0, 0, 0, 0);
        drain();

        write_reg(CFG_WIDTH, 20'd300);
        write_reg(CFG_HEIGHT, 20'd250);
        write_reg(CFG_RADIUS, 20'd20);
        write_reg(CFG_AGE, 20'd200000);
        stall_mode = 2;
        random_burst(50, 300, 250, 20);
        drain();

        write_reg(CFG_WIDTH, 20'd1);
        write_reg(CFG_HEIGHT, 20'd1);
        write_reg(CFG_RADIUS, 20'd255);
        write_reg(CFG_AGE, 20'd0);
        stall_mode = 0;
        send_request(1'b1, 0, 11'd0, 11'd0, 0, 0);
        send_request(1'b0, 16'd5, 0, 0, 0, 0);
        drain();

        write_reg(CFG_WIDTH, 20'd800);
        write_reg(CFG_HEIGHT, 20'd600);
        write_reg(CFG_RADIUS, 20'd30);
        write_reg(CFG_AGE, 20'd400000);
        stall_mode = 1;
        random_burst(60, 800, 600, 30);
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: bouncing_disc_collision_step.f
hw/rtl/bdcs_pkg.sv
hw/rtl/bdcs_div.sv
hw/rtl/bdcs_ctrl.sv
hw/rtl/bdcs_dp.sv
hw/rtl/bouncing_disc_collision_step.sv
hw/rtl/bdcs_chk.sv
sim/disc_table_checker.sv
sim/testbench.sv
